// ===== src/gfm_pkg.sv =====
`default_nettype none
package gfm_pkg;

	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = 4;
	localparam int FIELD_W   = WORD_W * NUM_WORDS;
	localparam int PROD_W    = 2 * FIELD_W;
	// x^256 + x^10 + x^5 + x^2 + 1, low taps only
	localparam int TAP_HI    = 10;
	localparam int TAP_MID   = 5;
	localparam int TAP_LO    = 2;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [PROD_W-1:0]  prod_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_MAC = 2'd1,
		OP_SQR = 2'd2
	} opcode_t;

endpackage
`default_nettype wire

// ===== src/gf2_256_multiply_accumulate.sv =====
// GF(2^256) multiply, multiply-accumulate and square unit.
// Input channel (s_*): s_tuser carries the opcode (0 multiply, 1 multiply and
// accumulate into the accumulator, 2 square a, 3 no operation); s_tdata carries
// a_word0..a_word3 then b_word0..b_word3, 64 bits each, lowest word first.
// Output channel (m_*): one item per input item, m_tdata = accumulator value
// after the operation, r_word0..r_word3 from the lowest bits up.
// The item is registered on acceptance, then the 256x256 carry-less product,
// the reduction by x^256+x^10+x^5+x^2+1 and the accumulator update run
// combinationally into the output register.
// Throughput is one item per cycle while m_tready is high; the product tree
// between the input and output registers sets the clock period.
// While m_tready is low the output register holds its item, the input register
// can still take one more item, and s_tready falls only when both are full.
// Reset clears both valid flags and sets the accumulator to zero.
`default_nettype none
module gf2_256_multiply_accumulate (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [511:0] s_tdata,   // a_word0, a_word1, a_word2, a_word3, b_word0..b_word3
	input  wire [1:0]   s_tuser,   // opcode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [255:0] m_tdata   // r_word0, r_word1, r_word2, r_word3
);
	import gfm_pkg::*;

	logic        valid_s1;
	logic [1:0]  opcode_s1;
	field_t      a_s1;
	field_t      b_s1;
	logic        valid_s2;
	field_t      r_s2;
	field_t      acc_q;

	field_t      mul_y;
	prod_t       prod;
	field_t      red;
	field_t      acc_next;
	logic        s2_free;
	logic        adv;

	assign s2_free  = !valid_s2 || m_tready;
	assign adv      = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign m_tvalid = valid_s2;
	assign m_tdata  = r_s2;

	assign mul_y = (opcode_s1 == OP_SQR) ? a_s1 : b_s1;

	gfm_clmul256 u_clmul (
		.x (a_s1),
		.y (mul_y),
		.p (prod)
	);

	gfm_reduce u_reduce (
		.p (prod),
		.r (red)
	);

	always_comb begin
		unique case (opcode_s1)
			OP_MUL:  acc_next = red;
			OP_MAC:  acc_next = acc_q ^ red;
			OP_SQR:  acc_next = red;
			default: acc_next = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (adv)
				acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1 <= s_tuser;
			a_s1      <= s_tdata[FIELD_W-1:0];
			b_s1      <= s_tdata[PROD_W-1:FIELD_W];
		end
		if (adv)
			r_s2 <= acc_next;
	end

endmodule
`default_nettype wire

// ===== src/gfm_clmul256.sv =====
`default_nettype none
module gfm_clmul256 (
	input  wire gfm_pkg::field_t x,
	input  wire gfm_pkg::field_t y,
	output gfm_pkg::prod_t       p
);
	import gfm_pkg::*;

	localparam int PP_W = 2 * WORD_W;

	// each product bit is the parity of its own and-vector, so no serial xor chain
	function automatic logic [PP_W-1:0] clmul64(input word_t a, input word_t b);
		logic [PP_W-1:0] r;
		logic [WORD_W-1:0] t;
		for (int k = 0; k < PP_W; k++) begin
			for (int i = 0; i < WORD_W; i++) begin
				if (k - i >= 0 && k - i < WORD_W)
					t[i] = a[i] & b[k-i];
				else
					t[i] = 1'b0;
			end
			r[k] = ^t;
		end
		return r;
	endfunction

	logic [PP_W-1:0] pp [NUM_WORDS][NUM_WORDS];

	for (genvar i = 0; i < NUM_WORDS; i++) begin : g_row
		for (genvar j = 0; j < NUM_WORDS; j++) begin : g_col
			assign pp[i][j] = clmul64(x[i*WORD_W +: WORD_W], y[j*WORD_W +: WORD_W]);
		end
	end

	always_comb begin
		p = '0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			for (int j = 0; j < NUM_WORDS; j++) begin
				p[(i+j)*WORD_W +: PP_W] = p[(i+j)*WORD_W +: PP_W] ^ pp[i][j];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/gfm_reduce.sv =====
`default_nettype none
module gfm_reduce (
	input  wire gfm_pkg::prod_t p,
	output gfm_pkg::field_t     r
);
	import gfm_pkg::*;

	localparam int G_W    = FIELD_W + TAP_HI;
	localparam int FOLD_W = 2 * TAP_HI;

	logic [G_W-1:0]    h_ext;
	logic [G_W-1:0]    g;
	logic [TAP_HI-1:0] top;
	logic [FOLD_W-1:0] top_ext;
	logic [FOLD_W-1:0] fold;

	always_comb begin
		h_ext   = {{TAP_HI{1'b0}}, p[PROD_W-1:FIELD_W]};
		g       = (h_ext << TAP_HI) ^ (h_ext << TAP_MID) ^ (h_ext << TAP_LO);
		// bits 256..265 of g wrap around once more
		top     = g[G_W-1:FIELD_W];
		top_ext = {{TAP_HI{1'b0}}, top};
		fold    = top_ext ^ (top_ext << TAP_HI) ^ (top_ext << TAP_MID) ^ (top_ext << TAP_LO);
		r       = p[FIELD_W-1:0] ^ p[PROD_W-1:FIELD_W] ^ g[FIELD_W-1:0]
		          ^ {{(FIELD_W-FOLD_W){1'b0}}, fold};
	end

endmodule
`default_nettype wire

// ===== tb/gf2_256_mac_checker.sv =====
`default_nettype none
module gf2_256_mac_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	input  wire          s_tready,
	input  wire [511:0]  s_tdata,   // a_word0..a_word3, b_word0..b_word3
	input  wire [1:0]    s_tuser,   // opcode
	input  wire          m_tvalid,
	input  wire          m_tready,
	input  wire [255:0]  m_tdata,   // r_word0..r_word3
	output int           fail_count,
	output int           results_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import gfm_pkg::*;

	field_t acc_model;
	field_t acc_expected[$];

	// carry-less 256x256 product, reduced by x^256 + x^10 + x^5 + x^2 + 1
	function automatic field_t gf_product(input field_t x, input field_t y);
		logic [PROD_W-1:0]  wide;
		logic [FIELD_W-1:0] upper;
		logic [FIELD_W+9:0] folded;
		field_t             spill;
		wide = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (y[i]) begin
				wide ^= {{FIELD_W{1'b0}}, x} << i;
			end
		end
		upper  = wide[PROD_W-1:FIELD_W];
		folded = {10'b0, upper};
		folded = folded ^ (folded << TAP_HI) ^ (folded << TAP_MID) ^ (folded << TAP_LO);
		// bits 256..265 of the first fold go around once more
		spill = field_t'(folded[FIELD_W+9:FIELD_W]);
		spill = spill ^ (spill << TAP_HI) ^ (spill << TAP_MID) ^ (spill << TAP_LO);
		return wide[FIELD_W-1:0] ^ folded[FIELD_W-1:0] ^ spill;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_t a_op;
		field_t b_op;
		field_t want;
		if (!arst_n) begin
			acc_model = '0;
			acc_expected.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (acc_expected.size() == 0) begin
					$error("result item 0x%h with no item pending", m_tdata);
					fail_count++;
				end else begin
					want = acc_expected.pop_front();
					for (int k = 0; k < NUM_WORDS; k++) begin
						if (m_tdata[k*WORD_W +: WORD_W] !== want[k*WORD_W +: WORD_W]) begin
							$error("r_word%0d: expected 0x%h, got 0x%h", k,
								want[k*WORD_W +: WORD_W], m_tdata[k*WORD_W +: WORD_W]);
							fail_count++;
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				a_op = s_tdata[FIELD_W-1:0];
				b_op = s_tdata[2*FIELD_W-1:FIELD_W];
				case (opcode_t'(s_tuser))
					OP_MUL: acc_model = gf_product(a_op, b_op);
					OP_MAC: acc_model = acc_model ^ gf_product(a_op, b_op);
					OP_SQR: acc_model = gf_product(a_op, a_op);
					default: ;  // unused opcode leaves the accumulator alone
				endcase
				acc_expected.push_back(acc_model);
			end
		end
		results_owed = acc_expected.size();
	end

endmodule
`default_nettype wire

// ===== tb/gf2_256_multiply_accumulate_tb.sv =====
`default_nettype none
module gf2_256_multiply_accumulate_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gfm_pkg::*;

	localparam logic [1:0] OP_HOLD = 2'd3;
	localparam int RANDOM_ITEMS = 1150;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [511:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [255:0] m_tdata;
	logic         s_fire = 1'b0;
	int           fail_count;
	int           results_owed;

	gf2_256_multiply_accumulate u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gf2_256_mac_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// handshake seen at the edge, read by the driver at the next falling edge
	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready && arst_n;
	end

	// receiver: modes of always ready, random holds and long stalls
	initial begin
		int mode;
		int mode_left;
		int stall_left;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(40, 200);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 9) < 6);
					default: begin
						if ($urandom_range(0, 7) == 0) begin
							stall_left = $urandom_range(3, 12);
							m_tready <= 1'b0;
						end else begin
							m_tready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic field_t rand_field();
		field_t f;
		case ($urandom_range(0, 9))
			0: f = field_t'(1) << $urandom_range(0, FIELD_W - 1);
			1: f = '1;
			default: begin
				for (int k = 0; k < NUM_WORDS; k++) begin
					f[k*WORD_W +: WORD_W] = rand_word();
				end
			end
		endcase
		return f;
	endfunction

	function automatic logic [1:0] rand_opcode();
		case ($urandom_range(0, 9))
			0, 1, 2: return OP_MUL;
			3, 4, 5: return OP_MAC;
			6, 7, 8: return OP_SQR;
			default: return OP_HOLD;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] op, input field_t a, input field_t b);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, a};
		do @(negedge clk); while (!s_fire);
	endtask

	task automatic pause_sender(input int cycles);
		s_tvalid <= 1'b0;
		s_tuser <= 2'($urandom_range(0, 3));
		s_tdata <= {rand_field(), rand_field()};
		repeat (cycles) @(negedge clk);
	endtask

	initial begin
		field_t top_bit;
		int burst_left;
		top_bit = field_t'(1) << (FIELD_W - 1);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, every opcode, unused opcode, squaring ignores b
		send_item(OP_HOLD, '1, '1);
		send_item(OP_MUL, '0, '0);
		send_item(OP_MUL, '1, '1);
		send_item(OP_MUL, field_t'(1), '1);
		send_item(OP_MUL, top_bit, field_t'(2));
		send_item(OP_MUL, top_bit, top_bit);
		send_item(OP_MAC, '1, '1);
		send_item(OP_MAC, top_bit, '1);
		send_item(OP_HOLD, rand_field(), rand_field());
		send_item(OP_SQR, '1, rand_field());
		send_item(OP_SQR, top_bit, '1);
		send_item(OP_SQR, '0, '1);
		send_item(OP_MAC, '0, '1);
		send_item(OP_HOLD, '0, '0);
		send_item(OP_MAC, rand_field(), rand_field());
		send_item(OP_MAC, rand_field(), rand_field());
		send_item(OP_MUL, rand_field(), '0);
		send_item(OP_SQR, field_t'(1), '0);
		send_item(OP_MAC, '1, top_bit);

		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0) begin
					pause_sender($urandom_range(1, 6));
				end
			end
			burst_left--;
			send_item(rand_opcode(), rand_field(), rand_field());
		end
		s_tvalid <= 1'b0;

		while (results_owed != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS gf2_256_multiply_accumulate");
		end else begin
			$display("FAIL gf2_256_multiply_accumulate");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL gf2_256_multiply_accumulate");
		$finish;
	end

endmodule
`default_nettype wire
